@@ src/sdalu_pkg.sv @@
// sdalu_pkg: shared types, constants and the divide step for the signed duration ALU.
// Used by signed_duration_alu_unit; depends on nothing else.
package sdalu_pkg;

	localparam int unsigned SEC_W     = 64;
	localparam int unsigned NS_W      = 30;
	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned NS_STEPS  = 30;

	localparam logic [NS_W-1:0]  NS_MAX          = 30'd999999999;
	localparam logic [NS_W-1:0]  NS_PER_SEC30    = 30'd1000000000;
	localparam logic [NS_W:0]    NS_PER_SEC      = 31'd1000000000;
	localparam logic [SEC_W-1:0] MAX_SECONDS_RST = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_NEG = 3'd4,
		CMD_CMP = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_OVF   = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	localparam logic signed [1:0] ORD_LT = -2'sd1;
	localparam logic signed [1:0] ORD_EQ = 2'sd0;
	localparam logic signed [1:0] ORD_GT = 2'sd1;

	// front end, stages 1 to 3
	typedef struct packed {
		logic              valid;
		cmd_t              cmd;
		logic [SEC_W-1:0]  a_s;
		logic [NS_W-1:0]   a_n;
		logic              a_neg;
		logic [SEC_W-1:0]  b_s;
		logic [NS_W-1:0]   b_n;
		logic              b_neg;
		logic [SEC_W-1:0]  k;
		logic [63:0]       pp_ll;
		logic [63:0]       pp_lh;
		logic [63:0]       pp_hl;
		logic [63:0]       pp_hh;
		logic [61:0]       pn_l;
		logic [61:0]       pn_h;
		logic [SEC_W:0]    sum_s;
		logic [NS_W:0]     sum_n;
		logic              lt;
		logic              eq;
		logic [64:0]       mid;
		logic [93:0]       pbig;
		logic [SEC_W-1:0]  res_s;
		logic [NS_W-1:0]   res_n;
		logic              res_neg;
		logic signed [1:0] ord;
		logic              add_ovf;
	} front_t;

	// divider and back end
	typedef struct packed {
		logic              valid;
		cmd_t              cmd;
		logic [NS_W-1:0]   a_n;
		logic              a_neg;
		logic              k_zero;
		logic [SEC_W-1:0]  res_s;
		logic [NS_W-1:0]   res_n;
		logic              res_neg;
		logic signed [1:0] ord;
		status_t           st;
		logic              mul_ovf;
		logic [63:0]       prod_lo;
		logic [63:0]       rem;
		logic [63:0]       q;
		logic [63:0]       d;
		logic [63:0]       quo_s;
		logic [NS_W-1:0]   mns;
		logic [64:0]       msum;
		logic [61:0]       pr_l;
		logic [61:0]       pr_h;
	} div_t;

	// one restoring step: next dividend bit from q[63], quotient bit into q[0]
	function automatic div_t div_step(input div_t x);
		div_t        y;
		logic [64:0] r;
		logic        hit;
		y   = x;
		r   = {x.rem, x.q[63]};
		hit = (r >= {1'b0, x.d});
		if (hit) begin
			r = r - {1'b0, x.d};
		end
		y.rem = r[63:0];
		y.q   = {x.q[62:0], hit};
		return y;
	endfunction

endpackage

@@ src/signed_duration_alu_unit.sv @@
// signed_duration_alu_unit: pipelined add/sub/mul/div/negate/compare on durations.
// Depends on sdalu_pkg (types, constants, divide step).
//
// One command is taken every clock cycle (busy stays low). Its result beat is driven
// on done in issue order, for one cycle; the receiver cannot stall. A command first
// passes the front stages that form the partial products, then the divider: 64
// restoring steps for the seconds quotient (shared with the nanosecond split of
// multiply, which divides by one billion), then 30 steps for the nanosecond
// quotient. max_seconds is written over its own channel, always ready; write it
// only while no command is in flight.
module signed_duration_alu_unit
	import sdalu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           command,
	input  logic [SEC_W-1:0]     a_seconds,
	input  logic [NS_W-1:0]      a_nanoseconds,
	input  logic                 a_negative,
	input  logic [SEC_W-1:0]     b_seconds,
	input  logic [NS_W-1:0]      b_nanoseconds,
	input  logic                 b_negative,
	input  logic [SEC_W-1:0]     scalar,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SEC_W-1:0]     cfg_data,
	output logic                 done,
	output logic [SEC_W-1:0]     r_seconds,
	output logic [NS_W-1:0]      r_nanoseconds,
	output logic                 r_negative,
	output logic signed [1:0]    order,
	output logic [1:0]           status
);

	logic [SEC_W-1:0] max_seconds_q;

	front_t f_s1, f_s2, f_s3;
	front_t n1, n2, n3;
	div_t   n4, nm1, nm2;
	div_t   dstep_s [0:DIV_STEPS];
	div_t   m1_s;
	div_t   tstep_s [0:NS_STEPS];

	logic                 done_q;
	logic [SEC_W-1:0]     rs_q;
	logic [NS_W-1:0]      rn_q;
	logic                 rneg_q;
	logic signed [1:0]    ord_q;
	status_t              st_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seconds_q <= MAX_SECONDS_RST;
		end else if (cfg_valid) begin
			max_seconds_q <= cfg_data;
		end
	end

	// stage 1: capture, saturate nanoseconds
	always_comb begin
		n1       = '0;
		n1.valid = start;
		n1.cmd   = cmd_t'(command);
		n1.a_s   = a_seconds;
		n1.a_n   = (a_nanoseconds > NS_MAX) ? NS_MAX : a_nanoseconds;
		n1.a_neg = a_negative;
		n1.b_s   = b_seconds;
		n1.b_n   = (b_nanoseconds > NS_MAX) ? NS_MAX : b_nanoseconds;
		n1.b_neg = b_negative;
		n1.k     = scalar;
	end

	// stage 2: partial products, raw sums, magnitude compare
	always_comb begin
		n2       = f_s1;
		n2.pp_ll = f_s1.a_s[31:0]  * f_s1.k[31:0];
		n2.pp_lh = f_s1.a_s[31:0]  * f_s1.k[63:32];
		n2.pp_hl = f_s1.a_s[63:32] * f_s1.k[31:0];
		n2.pp_hh = f_s1.a_s[63:32] * f_s1.k[63:32];
		n2.pn_l  = f_s1.a_n * f_s1.k[31:0];
		n2.pn_h  = f_s1.a_n * f_s1.k[63:32];
		n2.sum_s = {1'b0, f_s1.a_s} + {1'b0, f_s1.b_s};
		n2.sum_n = {1'b0, f_s1.a_n} + {1'b0, f_s1.b_n};
		n2.lt    = (f_s1.a_s < f_s1.b_s) ||
			((f_s1.a_s == f_s1.b_s) && (f_s1.a_n < f_s1.b_n));
		n2.eq    = (f_s1.a_s == f_s1.b_s) && (f_s1.a_n == f_s1.b_n);
	end

	// stage 3: add/sub/negate/compare results, product middle terms
	always_comb begin
		logic             beff;
		logic [SEC_W:0]   ss;
		logic [NS_W:0]    ns;
		logic [SEC_W-1:0] xs, ys;
		logic [NS_W-1:0]  xn, yn;
		n3         = f_s2;
		n3.mid     = {1'b0, f_s2.pp_lh} + {1'b0, f_s2.pp_hl};
		n3.pbig    = {32'b0, f_s2.pn_l} + {f_s2.pn_h, 32'b0};
		n3.res_s   = '0;
		n3.res_n   = '0;
		n3.res_neg = 1'b0;
		n3.ord     = ORD_EQ;
		n3.add_ovf = 1'b0;
		beff = (f_s2.cmd == CMD_ADD) ? f_s2.b_neg : !f_s2.b_neg;
		ss   = f_s2.sum_s;
		ns   = f_s2.sum_n;
		xs   = f_s2.lt ? f_s2.b_s : f_s2.a_s;
		ys   = f_s2.lt ? f_s2.a_s : f_s2.b_s;
		xn   = f_s2.lt ? f_s2.b_n : f_s2.a_n;
		yn   = f_s2.lt ? f_s2.a_n : f_s2.b_n;
		unique case (f_s2.cmd)
			CMD_ADD, CMD_SUB: begin
				if (f_s2.a_neg == beff) begin
					// like signs: add magnitudes, carry nanoseconds
					if (f_s2.sum_n >= NS_PER_SEC) begin
						ns = f_s2.sum_n - NS_PER_SEC;
						ss = f_s2.sum_s + 65'd1;
					end
					n3.res_s   = ss[SEC_W-1:0];
					n3.res_n   = ns[NS_W-1:0];
					n3.res_neg = f_s2.a_neg;
					n3.add_ovf = ss[SEC_W];
				end else if (!f_s2.eq) begin
					// unlike signs: larger minus smaller, larger one's sign
					n3.res_neg = f_s2.lt ? beff : f_s2.a_neg;
					if (xn < yn) begin
						n3.res_s = xs - ys - 64'd1;
						ns       = ({1'b0, xn} + NS_PER_SEC) - {1'b0, yn};
						n3.res_n = ns[NS_W-1:0];
					end else begin
						n3.res_s = xs - ys;
						n3.res_n = xn - yn;
					end
				end
			end
			CMD_NEG: begin
				n3.res_s   = f_s2.a_s;
				n3.res_n   = f_s2.a_n;
				n3.res_neg = !f_s2.a_neg;
			end
			CMD_CMP: begin
				if (f_s2.a_neg && !f_s2.b_neg) begin
					n3.ord = ORD_LT;
				end else if (!f_s2.a_neg && f_s2.b_neg) begin
					n3.ord = ORD_GT;
				end else if (f_s2.eq) begin
					n3.ord = ORD_EQ;
				end else if (f_s2.lt != f_s2.a_neg) begin
					n3.ord = ORD_LT;
				end else begin
					n3.ord = ORD_GT;
				end
			end
			default: begin
			end
		endcase
	end

	// stage 4: full product, range check, divider load
	always_comb begin
		logic [127:0] prod;
		prod = {64'b0, f_s3.pp_ll} + {31'b0, f_s3.mid, 32'b0} + {f_s3.pp_hh, 64'b0};
		n4         = '0;
		n4.valid   = f_s3.valid;
		n4.cmd     = f_s3.cmd;
		n4.a_n     = f_s3.a_n;
		n4.a_neg   = f_s3.a_neg;
		n4.k_zero  = (f_s3.k == '0);
		n4.res_s   = f_s3.res_s;
		n4.res_n   = f_s3.res_n;
		n4.res_neg = f_s3.res_neg;
		n4.ord     = f_s3.ord;
		n4.st      = ST_OK;
		if ((f_s3.cmd == CMD_ADD || f_s3.cmd == CMD_SUB) &&
			(f_s3.add_ovf || f_s3.res_s > max_seconds_q)) begin
			n4.st = ST_RANGE;
		end
		n4.mul_ovf = |prod[127:64];
		n4.prod_lo = prod[63:0];
		if (f_s3.cmd == CMD_MUL) begin
			// split a_n * k into whole seconds and nanoseconds
			n4.d   = {34'b0, NS_PER_SEC30};
			n4.rem = {34'b0, f_s3.pbig[93:64]};
			n4.q   = f_s3.pbig[63:0];
		end else begin
			n4.d   = f_s3.k;
			n4.rem = '0;
			n4.q   = f_s3.a_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s1.valid       <= 1'b0;
			f_s2.valid       <= 1'b0;
			f_s3.valid       <= 1'b0;
			dstep_s[0].valid <= 1'b0;
		end else begin
			f_s1       <= n1;
			f_s2       <= n2;
			f_s3       <= n3;
			dstep_s[0] <= n4;
		end
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_sec_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dstep_s[j].valid <= 1'b0;
			end else begin
				dstep_s[j] <= div_step(dstep_s[j-1]);
			end
		end
	end

	// remainder times one billion, multiply final sum
	always_comb begin
		nm1       = dstep_s[DIV_STEPS];
		nm1.quo_s = dstep_s[DIV_STEPS].q;
		nm1.mns   = dstep_s[DIV_STEPS].rem[NS_W-1:0];
		nm1.msum  = {1'b0, dstep_s[DIV_STEPS].prod_lo} + {1'b0, dstep_s[DIV_STEPS].q};
		nm1.pr_l  = dstep_s[DIV_STEPS].rem[31:0]  * NS_PER_SEC30;
		nm1.pr_h  = dstep_s[DIV_STEPS].rem[63:32] * NS_PER_SEC30;
	end

	// nanosecond dividend; top part is already below the divisor
	always_comb begin
		logic [93:0] nsum;
		nsum    = {32'b0, m1_s.pr_l} + {m1_s.pr_h, 32'b0} + {64'b0, m1_s.a_n};
		nm2     = m1_s;
		nm2.rem = nsum[93:30];
		nm2.q   = {nsum[29:0], 34'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_s.valid       <= 1'b0;
			tstep_s[0].valid <= 1'b0;
		end else begin
			m1_s       <= nm1;
			tstep_s[0] <= nm2;
		end
	end

	for (genvar j = 1; j <= NS_STEPS; j++) begin : g_ns_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tstep_s[j].valid <= 1'b0;
			end else begin
				tstep_s[j] <= div_step(tstep_s[j-1]);
			end
		end
	end

	// result assembly
	div_t fin;
	always_comb begin
		fin = tstep_s[NS_STEPS];
		unique case (tstep_s[NS_STEPS].cmd)
			CMD_DIV: begin
				if (tstep_s[NS_STEPS].k_zero) begin
					fin.st = ST_DIVZ;
				end else begin
					fin.res_s   = tstep_s[NS_STEPS].quo_s;
					fin.res_n   = tstep_s[NS_STEPS].q[NS_W-1:0];
					fin.res_neg = tstep_s[NS_STEPS].a_neg;
				end
			end
			CMD_MUL: begin
				if (!tstep_s[NS_STEPS].k_zero) begin
					if (tstep_s[NS_STEPS].mul_ovf || tstep_s[NS_STEPS].msum[64]) begin
						fin.st = ST_OVF;
					end else begin
						fin.res_s   = tstep_s[NS_STEPS].msum[63:0];
						fin.res_n   = tstep_s[NS_STEPS].mns;
						fin.res_neg = tstep_s[NS_STEPS].a_neg;
					end
				end
			end
			default: begin
			end
		endcase
		if (fin.st != ST_OK) begin
			fin.res_s   = '0;
			fin.res_n   = '0;
			fin.res_neg = 1'b0;
		end
		if (fin.res_s == '0 && fin.res_n == '0) begin
			fin.res_neg = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
			rs_q   <= fin.res_s;
			rn_q   <= fin.res_n;
			rneg_q <= fin.res_neg;
			ord_q  <= fin.ord;
			st_q   <= fin.st;
		end
	end

	assign done          = done_q;
	assign r_seconds     = rs_q;
	assign r_nanoseconds = rn_q;
	assign r_negative    = rneg_q;
	assign order         = ord_q;
	assign status        = st_q;

	// any error result carries a zero duration
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> r_seconds == '0 && r_nanoseconds == '0 && !r_negative)
		else $error("error beat with non-zero duration");

	a_ns_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> r_nanoseconds < NS_PER_SEC30)
		else $error("nanoseconds out of range");

	a_ord_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && order != ORD_EQ |-> status == ST_OK && r_seconds == '0 &&
			r_nanoseconds == '0)
		else $error("order set with a duration result");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && r_negative |-> r_seconds != '0 || r_nanoseconds != '0)
		else $error("negative zero result");

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for signed_duration_alu_unit (add, sub, multiply, divide,
// negate and compare on sign-magnitude durations, plus the max_seconds register).
// Depends on sdalu_pkg and the unit itself; needs no files or arguments.
module tb_top;
	import sdalu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// extra idle margin once every expected result beat has been checked
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [63:0]       secs;
		logic [29:0]       nsec;
		logic              neg;
		logic signed [1:0] ord;
		status_t           st;
	} duration_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] command = '0;
	logic [63:0] a_seconds = '0, b_seconds = '0, scalar = '0;
	logic [29:0] a_nanoseconds = '0, b_nanoseconds = '0;
	logic a_negative = 1'b0, b_negative = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [63:0] cfg_data = '0;
	logic done;
	logic [63:0] r_seconds;
	logic [29:0] r_nanoseconds;
	logic r_negative;
	logic signed [1:0] order;
	logic [1:0] status;

	logic [63:0] sec_limit;       // testbench copy of max_seconds
	duration_res_t pending_q[$];  // expected results, oldest first
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned idle_pct = 0;    // sender idle chance, percent

	signed_duration_alu_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.a_seconds(a_seconds), .a_nanoseconds(a_nanoseconds), .a_negative(a_negative),
		.b_seconds(b_seconds), .b_nanoseconds(b_nanoseconds), .b_negative(b_negative),
		.scalar(scalar), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .r_seconds(r_seconds), .r_nanoseconds(r_nanoseconds),
		.r_negative(r_negative), .order(order), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int mag_order(logic [63:0] xs, logic [29:0] xn,
			logic [63:0] ys, logic [29:0] yn);
		if (xs != ys) return (xs < ys) ? -1 : 1;
		if (xn != yn) return (xn < yn) ? -1 : 1;
		return 0;
	endfunction

	// expected outcome of one command at the current max_seconds
	function automatic duration_res_t duration_result(logic [2:0] cmd,
			logic [63:0] as, logic [29:0] an_in, logic aneg,
			logic [63:0] bs, logic [29:0] bn_in, logic bneg, logic [63:0] k);
		duration_res_t res;
		logic [29:0] an, bn;
		logic beff;
		logic [64:0] wide_s;
		logic [30:0] wide_n;
		logic [191:0] prod, quot, prem;
		logic [127:0] numer;
		int c;
		an = (an_in > NS_MAX) ? NS_MAX : an_in;
		bn = (bn_in > NS_MAX) ? NS_MAX : bn_in;
		res.secs = '0; res.nsec = '0; res.neg = 1'b0; res.ord = ORD_EQ; res.st = ST_OK;
		case (cmd)
			CMD_ADD, CMD_SUB: begin
				beff = (cmd == CMD_ADD) ? bneg : !bneg;
				if (aneg == beff) begin
					wide_s = {1'b0, as} + {1'b0, bs};
					wide_n = {1'b0, an} + {1'b0, bn};
					if (wide_n >= NS_PER_SEC) begin
						wide_n = wide_n - NS_PER_SEC;
						wide_s = wide_s + 65'd1;
					end
					res.secs = wide_s[63:0]; res.nsec = wide_n[29:0]; res.neg = aneg;
					if (wide_s[64] || wide_s[63:0] > sec_limit) res.st = ST_RANGE;
				end else begin
					c = mag_order(as, an, bs, bn);
					res.neg = aneg;
					if (c < 0) begin
						res.secs = bs - as - ((bn < an) ? 1 : 0);
						res.nsec = (bn < an) ? bn + NS_PER_SEC30 - an : bn - an;
						res.neg = beff;
					end else if (c > 0) begin
						res.secs = as - bs - ((an < bn) ? 1 : 0);
						res.nsec = (an < bn) ? an + NS_PER_SEC30 - bn : an - bn;
					end
					if (res.secs > sec_limit) res.st = ST_RANGE;
				end
			end
			CMD_MUL: begin
				// exact product in nanoseconds, then split; overflow if seconds > 64 bits
				prod = ({128'd0, as} * 192'd1000000000 + {162'd0, an}) * {128'd0, k};
				if (k != 0) begin
					quot = prod / 192'd1000000000;
					prem = prod % 192'd1000000000;
					if (quot[191:64] != '0) res.st = ST_OVF;
					else begin
						res.secs = quot[63:0];
						res.nsec = prem[29:0];
						res.neg = aneg;
					end
				end
			end
			CMD_DIV: begin
				if (k == 0) res.st = ST_DIVZ;
				else begin
					res.secs = as / k;
					numer = {64'd0, as % k} * 128'd1000000000 + an;
					res.nsec = numer / k;
					res.neg = aneg;
				end
			end
			CMD_NEG: begin
				res.secs = as; res.nsec = an; res.neg = !aneg;
			end
			CMD_CMP: begin
				if (aneg && !bneg) res.ord = ORD_LT;
				else if (!aneg && bneg) res.ord = ORD_GT;
				else res.ord = aneg ? mag_order(bs, bn, as, an) : mag_order(as, an, bs, bn);
			end
			default: ;
		endcase
		if (res.st != ST_OK) begin
			res.secs = '0; res.nsec = '0; res.neg = 1'b0;
		end
		if (res.secs == 0 && res.nsec == 0) res.neg = 1'b0;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	// result checker: every done beat is matched against the oldest expectation
	always @(posedge clk) begin
		duration_res_t w;
		if (arst_n && done) begin
			if (pending_q.size() == 0) report_mismatch("unexpected beat", 0, 0);
			else begin
				w = pending_q.pop_front();
				if (r_seconds !== w.secs) report_mismatch("r_seconds", r_seconds, w.secs);
				if (r_nanoseconds !== w.nsec)
					report_mismatch("r_nanoseconds", r_nanoseconds, w.nsec);
				if (r_negative !== w.neg) report_mismatch("r_negative", r_negative, w.neg);
				if (order !== w.ord) report_mismatch("order", order, w.ord);
				if (status !== w.st) report_mismatch("status", status, w.st);
			end
		end
	end

	// one command beat; random idle gap before it in idle phases
	task automatic send_item(logic [2:0] cmd, logic [63:0] as, logic [29:0] an, logic aneg,
			logic [63:0] bs, logic [29:0] bn, logic bneg, logic [63:0] k);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1; command <= cmd;
		a_seconds <= as; a_nanoseconds <= an; a_negative <= aneg;
		b_seconds <= bs; b_nanoseconds <= bn; b_negative <= bneg; scalar <= k;
		do @(posedge clk); while (busy);
		pending_q.push_back(duration_result(cmd, as, an, aneg, bs, bn, bneg, k));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, only once the pipeline is empty
	task automatic write_max_seconds(logic [63:0] v);
		drain();
		cfg_valid <= 1'b1; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sec_limit = v;
	endtask

	function automatic logic [63:0] rand_secs();
		case ($urandom_range(5))
			0: return '0;
			1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3);
			2: return $urandom_range(1000);
			3: return {32'd0, $urandom()};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic logic [29:0] rand_nsec();
		case ($urandom_range(5))
			0: return '0;
			1: return NS_MAX;
			2: return 30'h3FFF_FFFF - $urandom_range(1000);  // saturated on input
			default: return $urandom_range(999999999);
		endcase
	endfunction

	function automatic logic [63:0] rand_scalar();
		case ($urandom_range(6))
			0: return '0;
			1: return 64'd1;
			2: return $urandom_range(3000000000);
			3: return 64'hFFFF_FFFF_FFFF_FFFF;
			4: return {$urandom(), $urandom()} >> $urandom_range(63);
			default: return $urandom_range(100);
		endcase
	endfunction

	task automatic test_directed();
		logic [63:0] m;
		m = 64'hFFFF_FFFF_FFFF_FFFF;
		send_item(CMD_ADD, m, NS_MAX, 0, 0, 1, 0, 0);              // carry out of 64 bits
		send_item(CMD_ADD, 5, 600000000, 0, 3, 500000000, 0, 0);   // ns carry
		send_item(CMD_ADD, 5, 0, 1, 5, 0, 0, 0);                   // mixed sign to zero
		send_item(CMD_ADD, 2, 0, 0, 7, 1, 1, 0);                   // second larger
		send_item(CMD_SUB, 0, 0, 0, 0, 1, 0, 0);                   // smaller minus larger, negative
		send_item(CMD_SUB, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 1, 0, 1, 0); // past range
		send_item(CMD_ADD, 1, 30'h3FFF_FFFF, 0, 0, 30'h3B9A_CA00, 0, 0); // ns saturate
		send_item(CMD_MUL, 7, 5, 1, 0, 0, 0, 0);                   // by zero
		send_item(CMD_MUL, m, NS_MAX, 0, 0, 0, 0, 2);              // overflow
		send_item(CMD_MUL, 3, NS_MAX, 1, 0, 0, 0, 64'd5000000001);
		send_item(CMD_MUL, m, 1, 0, 0, 0, 0, 1);
		send_item(CMD_DIV, 9, 1, 0, 0, 0, 0, 0);                   // by zero
		send_item(CMD_DIV, m, NS_MAX, 1, 0, 0, 0, m - 1);
		send_item(CMD_DIV, 0, 1, 1, 0, 0, 0, 3);                   // to zero, positive
		send_item(CMD_NEG, m, NS_MAX, 0, 0, 0, 0, 0);
		send_item(CMD_NEG, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_CMP, 0, 0, 1, 0, 0, 0, 0);                   // -0 below +0
		send_item(CMD_CMP, 4, 2, 1, 4, 1, 1, 0);
		send_item(CMD_CMP, 4, 2, 0, 4, 2, 0, 0);
		send_item(CMD_CMP, 0, 0, 0, 1, 0, 1, 0);
		send_item(3'd6, m, 1, 1, m, 1, 1, m);                      // unused commands
		send_item(3'd7, 1, 1, 0, 1, 1, 0, 1);
	endtask

	task automatic test_random(int unsigned count);
		repeat (count)
			send_item($urandom_range(7), rand_secs(), rand_nsec(), $urandom_range(1),
				rand_secs(), rand_nsec(), $urandom_range(1), rand_scalar());
	endtask

	initial begin
		sec_limit = MAX_SECONDS_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		idle_pct = 0;  test_random(150);
		write_max_seconds(64'd0);
		idle_pct = 53; test_random(150);
		write_max_seconds(64'hFFFF_FFFF_FFFF_FFFF);
		test_directed();
		idle_pct = 25; test_random(150);
		write_max_seconds({32'd0, $urandom()});
		idle_pct = 0;  test_random(100);
		write_max_seconds({$urandom(), $urandom()});
		idle_pct = 53; test_random(100);
		drain();
		if (mismatches == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
